// ===== hdl/sha2c_pkg.sv =====
// Shared types, constants and round functions for the SHA-256/SHA-224 core.
// Holds the round constant table, both initial hash values and the state encoding.
// No dependencies.
package sha2c_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS = 64;
	localparam int unsigned HASH_WORDS = 8;

	localparam logic [2:0] LAST_IDX_256 = 3'd7;
	localparam logic [2:0] LAST_IDX_224 = 3'd6;

	localparam logic MODE_SHA256 = 1'b0;
	localparam logic MODE_SHA224 = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t IV_256 [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t IV_224 [HASH_WORDS] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== hdl/sha256_224_compression.sv =====
// SHA-256 / SHA-224 hash core usage:
// Input requests carry one padded 32-bit message word each, sixteen to a block,
// with first_of_message marking the start of a message and last_of_message the
// final word of the final block. The mode register (cfg_write_en/cfg_write_data)
// picks SHA-256 (0) or SHA-224 (1); the user must write it only while the core
// is idle, and the core itself does not enforce this. Words 1 to 15 of a block
// are taken one per cycle. The sixteenth word starts the compression: a schedule
// prefetch state, 64 rounds at one per cycle and a chaining add state. The round
// loop over the schedule memory sets the block rate.
// in_stall is high for the whole compression and digest output.
// After the last block the digest leaves as 8 (SHA-256) or 7 (SHA-224) output
// requests, most significant word first, the first one valid once the chaining
// add state has finished; a stall on the output simply holds the current word.
// Reset clears the control state, selects SHA-256 and loads the SHA-256 initial
// value into the chaining hash; the schedule memory is not cleared.
// Depends on sha2c_pkg.
module sha256_224_compression
	import sha2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message_word,
	input  logic        first_of_message,
	input  logic        last_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);

	state_t     state_q;
	logic       mode_q;
	logic [3:0] wpos_q;
	logic [5:0] rnd_q;
	logic       last_q;
	logic       short_q;
	logic [2:0] idx_q;
	word_t      chain_q [HASH_WORDS];
	word_t      v_q [HASH_WORDS];

	word_t      sched_mem [BLOCK_WORDS];
	word_t      rd_a_q;
	word_t      rd_b_q;
	word_t      prev_a_q;
	word_t      w1_q;
	word_t      w2_q;

	logic       in_acc;
	logic       out_acc;
	logic [3:0] pos;
	logic [5:0] next_t;
	logic [3:0] addr_a;
	logic [3:0] addr_b;
	word_t      w_new;
	word_t      w_cur;
	word_t      t1;
	word_t      t2;
	word_t      ch;
	word_t      maj;
	logic [2:0] end_idx;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc = out_valid && !out_stall;
	assign pos = first_of_message ? 4'd0 : wpos_q;

	assign end_idx = short_q ? LAST_IDX_224 : LAST_IDX_256;
	assign digest_word = chain_q[idx_q];
	assign digest_index = idx_q;
	assign digest_last = (idx_q == end_idx);

	// Read addresses are issued in the cycle before the round that uses the data.
	// Port A fetches W[t-15], which prev_a_q keeps for the next round as W[t-16];
	// port B fetches W[t] during the first sixteen rounds and W[t-7] afterwards.
	assign next_t = (state_q == ST_ROUND) ? rnd_q + 6'd1 : 6'd0;
	assign addr_a = next_t[3:0] + 4'd1;
	assign addr_b = (next_t[5:4] == 2'd0) ? next_t[3:0] : next_t[3:0] + 4'd9;

	assign w_new = prev_a_q + small_sigma0(rd_a_q) + rd_b_q + small_sigma1(w2_q);
	assign w_cur = (rnd_q[5:4] == 2'd0) ? rd_b_q : w_new;

	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[rnd_q] + w_cur;
	assign t2 = big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sched_mem[pos] <= message_word;
		end else if (state_q == ST_ROUND && rnd_q[5:4] != 2'd0) begin
			sched_mem[rnd_q[3:0]] <= w_new;
		end
		rd_a_q <= sched_mem[addr_a];
		rd_b_q <= sched_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			prev_a_q <= rd_a_q;
			w2_q <= w1_q;
			w1_q <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SHA256;
		end else if (cfg_write_en) begin
			mode_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= IV_256[i];
			end
		end else if (in_acc && first_of_message) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= (mode_q == MODE_SHA224) ? IV_224[i] : IV_256[i];
			end
		end else if (state_q == ST_FINAL) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wpos_q <= '0;
			rnd_q <= '0;
			last_q <= 1'b0;
			short_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (pos == 4'd15) begin
							wpos_q <= '0;
							last_q <= last_of_message;
							short_q <= (mode_q == MODE_SHA224);
							state_q <= ST_PREP;
						end else begin
							wpos_q <= pos + 4'd1;
						end
					end
				end
				ST_PREP: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					idx_q <= '0;
					state_q <= last_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_acc) begin
						if (idx_q == end_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_sha256_224_compression.sv =====
// Self-checking testbench for the SHA-256/SHA-224 compression core.
// An internal hash model predicts every digest word, and each output request is compared with it.
// Depends on sha2c_pkg and sha256_224_compression.
module tb_sha256_224_compression;
	timeunit 1ns;
	timeprecision 1ps;
	import sha2c_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 100;

	localparam logic [64*32-1:0] ROUND_CONST = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [255:0] INIT_256 = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [255:0] INIT_224 = {
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	typedef struct {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_write_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] message_word = '0;
	logic        first_of_message = 1'b0;
	logic        last_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	// Hash model state, kept in step with the accepted requests.
	logic        hash_mode;
	word_t       chain [8];
	word_t       block_buf [16];
	int unsigned fill;

	digest_exp_t digest_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;
	int fails = 0;
	int words_sent = 0;
	int digests_predicted = 0;
	int digests_checked = 0;
	int cycles = 0;

	sha256_224_compression dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.message_word     (message_word),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.digest_word      (digest_word),
		.digest_index     (digest_index),
		.digest_last      (digest_last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("[sha256_224_compression] ERROR");
			$finish;
		end
	end

	function automatic word_t rotr32(input word_t x, input int n);
		logic [63:0] both;
		both = {x, x} >> n;
		return both[31:0];
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Feeds one accepted word into the hash model and queues any digest it completes.
	task automatic absorb_word(input word_t w, input logic is_first, input logic is_last);
		word_t sched [64];
		word_t v [8];
		word_t s0, s1, t1, t2;
		int count;
		if (is_first) begin
			for (int i = 0; i < 8; i++)
				chain[i] = (hash_mode == MODE_SHA224) ? INIT_224[(7 - i) * 32 +: 32]
					: INIT_256[(7 - i) * 32 +: 32];
			fill = 0;
		end
		block_buf[fill] = w;
		if (fill != 15) begin
			fill++;
			return;
		end
		fill = 0;
		for (int t = 0; t < 16; t++)
			sched[t] = block_buf[t];
		for (int t = 16; t < 64; t++) begin
			s0 = rotr32(sched[t-15], 7) ^ rotr32(sched[t-15], 18) ^ (sched[t-15] >> 3);
			s1 = rotr32(sched[t-2], 17) ^ rotr32(sched[t-2], 19) ^ (sched[t-2] >> 10);
			sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
		end
		v = chain;
		for (int t = 0; t < 64; t++) begin
			s1 = rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6]))
				+ ROUND_CONST[(63 - t) * 32 +: 32] + sched[t];
			s0 = rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--)
				v[i] = v[i-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
		if (!is_last)
			return;
		count = (hash_mode == MODE_SHA224) ? 7 : 8;
		for (int k = 0; k < count; k++) begin
			digest_q.push_back(digest_exp_t'{chain[k], 3'(k), k == count - 1});
			digests_predicted++;
		end
	endtask

	// Offers one request, with an occasional idle gap first, and holds it until accepted.
	task automatic send_word(input word_t w, input logic is_first, input logic is_last);
		int gap;
		gap = 0;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, 4);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		message_word <= w;
		first_of_message <= is_first;
		last_of_message <= is_last;
		do @(posedge clk); while (in_stall);
		words_sent++;
		absorb_word(w, is_first, is_last);
	endtask

	task automatic send_block(input logic with_first, input logic with_last, input logic stray);
		for (int k = 0; k < 16; k++)
			send_word(rand_word(), with_first && k == 0,
				(with_last && k == 15) || (stray && $urandom_range(7) == 0));
	endtask

	// Waits for every predicted digest word, then long enough for a compression
	// that produces no output to finish.
	task automatic drain_digests();
		@(negedge clk);
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= m;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		hash_mode = m;
	endtask

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_stall <= 1'b1;
			recv_hold--;
		end else begin
			out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_digest
		digest_exp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$display("%0t: expected no digest word, got %h index %0d last %b",
					$time, digest_word, digest_index, digest_last);
				fails++;
			end else begin
				want = digest_q.pop_front();
				digests_checked++;
				if (want.word !== digest_word) begin
					$display("%0t: digest_word expected %h, got %h", $time, want.word, digest_word);
					fails++;
				end
				if (want.index !== digest_index) begin
					$display("%0t: digest_index expected %0d, got %0d",
						$time, want.index, digest_index);
					fails++;
				end
				if (want.last !== digest_last) begin
					$display("%0t: digest_last expected %b, got %b", $time, want.last, digest_last);
					fails++;
				end
			end
		end
	end

	task automatic test_restart_and_mode_switch();
		write_mode(MODE_SHA256);
		// Words with no start mark form a partial block that the next start mark drops.
		repeat (3) send_word($urandom, 1'b0, 1'b0);
		send_block(1'b1, 1'b0, 1'b0);
		drain_digests();
		// The message started as SHA-256, so only the digest length follows the new mode.
		// The end mark on word seven comes too early and must be ignored.
		write_mode(MODE_SHA224);
		for (int k = 0; k < 16; k++)
			send_word(k[0] ? 32'hffffffff : 32'h0, 1'b0, k == 7 || k == 15);
		drain_digests();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_mode(MODE_SHA256);
		@(posedge clk);
		recv_hold = 300;
		// The second block continues the chaining value left by the first digest.
		send_block(1'b1, 1'b1, 1'b0);
		send_block(1'b0, 1'b1, 1'b0);
		drain_digests();
	endtask

	task automatic test_random_traffic(input int spct, input int rpct, input int n_words,
		input int n_digests);
		int words_goal, digest_goal, kind, nblk;
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		words_goal = words_sent + n_words;
		digest_goal = digests_predicted + n_digests;
		while (words_sent < words_goal || digests_predicted < digest_goal) begin
			if ($urandom_range(3) == 0) begin
				drain_digests();
				write_mode($urandom_range(1) ? MODE_SHA224 : MODE_SHA256);
			end
			kind = $urandom_range(99);
			if (kind < 70) begin
				nblk = ($urandom_range(4) == 0) ? 2 : 1;
				for (int b = 0; b < nblk; b++)
					send_block(b == 0, b == nblk - 1, 1'b0);
			end else if (kind < 80) begin
				send_block(1'b0, 1'b1, 1'b0);
			end else if (kind < 90) begin
				send_block(1'b1, 1'b1, 1'b1);
			end else begin
				repeat ($urandom_range(1, 15))
					send_word(rand_word(), $urandom_range(15) == 0, $urandom_range(3) == 0);
			end
		end
		drain_digests();
	endtask

	initial begin
		hash_mode = MODE_SHA256;
		for (int i = 0; i < 8; i++)
			chain[i] = INIT_256[(7 - i) * 32 +: 32];
		fill = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_restart_and_mode_switch();
		test_backpressure();
		test_random_traffic(36, 70, 14, 7);
		test_random_traffic(70, 36, 14, 7);
		test_random_traffic(0, 0, 14, 7);
		$display("Sent %0d message words in both digest modes, with restarts, early end marks,",
			words_sent);
		$display("chained messages and a long output hold; checked %0d digest words.",
			digests_checked);
		if (fails == 0)
			$display("[sha256_224_compression] OK");
		else
			$display("[sha256_224_compression] ERROR");
		$finish;
	end

endmodule
